// ===== src/sfr_pkg.sv =====
package sfr_pkg;

    localparam int MAX_FRAME   = 256;
    localparam int OFF_W       = $clog2(MAX_FRAME);
    localparam int CNT_W       = OFF_W + 1;
    localparam int NUM_SLOTS   = 3;
    localparam int SLOT_W      = 2;
    localparam int MEM_DEPTH   = NUM_SLOTS * MAX_FRAME;
    localparam int ADDR_W      = SLOT_W + OFF_W;
    localparam int LEN_W       = OFF_W + 1;
    localparam int OUTQ_DEPTH  = 4;
    localparam int OUTQ_PTR_W  = 2;
    localparam int OUTQ_CNT_W  = 3;
    localparam int PADDR_W     = 4;
    localparam int IN_DATA_W   = 16;
    localparam int OUT_DATA_W  = 16;

    localparam logic [1:0] REG_ENABLE     = 2'd0;
    localparam logic [1:0] REG_SPLIT_MASK = 2'd1;
    localparam logic [1:0] REG_SEQ_MASK   = 2'd2;

    localparam logic [7:0] SPLIT_MASK_RST = 8'h01;
    localparam logic [7:0] SEQ_MASK_RST   = 8'h0E;

    localparam logic CMD_RX_BYTE = 1'b0;
    localparam logic CMD_READ    = 1'b1;

    localparam logic [SLOT_W-1:0] SLOT_RX_RST = 2'd0;
    localparam logic [SLOT_W-1:0] SLOT_A_RST  = 2'd1;
    localparam logic [SLOT_W-1:0] SLOT_B_RST  = 2'd2;

    typedef struct packed {
        logic       enable;
        logic [7:0] split_mask;
        logic [7:0] seq_mask;
    } cfg_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } mem_wr_t;

    typedef struct packed {
        logic valid;
        logic last;
        logic overrun;
    } rd_info_t;

    typedef struct packed {
        logic       overrun;
        logic       last;
        logic       valid;
        logic [7:0] data;
    } out_item_t;

endpackage

// ===== src/sfr_cfg.sv =====
module sfr_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sfr_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output sfr_pkg::cfg_t                cfg
);
    import sfr_pkg::*;

    logic       enable_reg;
    logic [7:0] split_mask_reg;
    logic [7:0] seq_mask_reg;
    logic       wr_fire;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_fire = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg     <= 1'b0;
            split_mask_reg <= SPLIT_MASK_RST;
            seq_mask_reg   <= SEQ_MASK_RST;
        end
        else if (wr_fire)
        begin
            case (reg_idx)
                REG_ENABLE:     enable_reg     <= pwdata[0];
                REG_SPLIT_MASK: split_mask_reg <= pwdata[7:0];
                REG_SEQ_MASK:   seq_mask_reg   <= pwdata[7:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_ENABLE:     prdata = {31'b0, enable_reg};
            REG_SPLIT_MASK: prdata = {24'b0, split_mask_reg};
            REG_SEQ_MASK:   prdata = {24'b0, seq_mask_reg};
            default:        prdata = 32'b0;
        endcase
    end

    assign cfg.enable     = enable_reg;
    assign cfg.split_mask = split_mask_reg;
    assign cfg.seq_mask   = seq_mask_reg;

endmodule

// ===== src/sfr_ram.sv =====
module sfr_ram (
    input  logic                        clk,
    input  sfr_pkg::mem_wr_t            wr,
    input  logic                        rd_en,
    input  logic [sfr_pkg::ADDR_W-1:0]  rd_addr,
    output logic [7:0]                  rd_data
);
    import sfr_pkg::*;

    logic [7:0] mem [0:MEM_DEPTH-1];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/sfr_ctrl.sv =====
module sfr_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  sfr_pkg::cfg_t               cfg,
    input  logic                        in_fire,
    input  logic                        command,
    input  logic [7:0]                  rx_byte,
    input  logic                        frame_end,
    input  logic                        frame_bad,
    output sfr_pkg::mem_wr_t            mem_wr,
    output logic                        rd_en,
    output logic [sfr_pkg::ADDR_W-1:0]  rd_addr,
    output logic                        s1_valid,
    output sfr_pkg::rd_info_t           s1_info
);
    import sfr_pkg::*;

    // three frame slots rotate between receive, first segment and second segment
    logic [CNT_W-1:0]  fcount_reg,  fcount_next;
    logic [7:0]        hdr_reg,     hdr_next;
    logic [SLOT_W-1:0] rx_slot_reg, rx_slot_next;
    logic [SLOT_W-1:0] a_slot_reg,  a_slot_next;
    logic [SLOT_W-1:0] b_slot_reg,  b_slot_next;
    logic [OFF_W-1:0]  a_len_reg,   a_len_next;
    logic              half_reg,    half_next;
    logic [7:0]        pseq_reg,    pseq_next;
    logic [LEN_W-1:0]  pkt_len_reg, pkt_len_next;
    logic [LEN_W-1:0]  rptr_reg,    rptr_next;
    logic              ready_reg,   ready_next;
    logic              ovr_reg,     ovr_next;
    logic              s1_valid_reg;
    rd_info_t          s1_info_reg, s1_info_next;

    logic              store_ok;
    logic [CNT_W-1:0]  len;
    logic [OFF_W-1:0]  plen;
    logic              is_split;
    logic [7:0]        seq;
    logic              seq_match;
    logic              rd_avail;
    logic              in_a;
    logic [LEN_W-1:0]  rptr_inc;
    logic [LEN_W-1:0]  off_b;
    logic              rx_fire;
    logic              rd_fire;

    assign rx_fire   = in_fire && (command == CMD_RX_BYTE);
    assign rd_fire   = in_fire && (command == CMD_READ);
    assign store_ok  = fcount_reg < CNT_W'(MAX_FRAME);
    assign len       = fcount_reg + CNT_W'(store_ok);
    assign plen      = OFF_W'(len - CNT_W'(1));
    assign is_split  = |(hdr_reg & cfg.split_mask);
    assign seq       = hdr_reg & cfg.seq_mask;
    assign seq_match = half_reg && (pseq_reg == seq);

    assign rd_avail = ready_reg && (rptr_reg < pkt_len_reg);
    assign in_a     = rptr_reg < LEN_W'(a_len_reg);
    assign rptr_inc = rptr_reg + LEN_W'(1);
    assign off_b    = rptr_reg - LEN_W'(a_len_reg) + LEN_W'(1);

    assign mem_wr.we   = rx_fire && cfg.enable && store_ok;
    assign mem_wr.addr = {rx_slot_reg, fcount_reg[OFF_W-1:0]};
    assign mem_wr.data = rx_byte;

    assign rd_en   = rd_fire && rd_avail;
    assign rd_addr = in_a ? {a_slot_reg, rptr_inc[OFF_W-1:0]}
                          : {b_slot_reg, off_b[OFF_W-1:0]};

    always_comb
    begin
        fcount_next  = fcount_reg;
        hdr_next     = hdr_reg;
        rx_slot_next = rx_slot_reg;
        a_slot_next  = a_slot_reg;
        b_slot_next  = b_slot_reg;
        a_len_next   = a_len_reg;
        half_next    = half_reg;
        pseq_next    = pseq_reg;
        pkt_len_next = pkt_len_reg;
        rptr_next    = rptr_reg;
        ready_next   = ready_reg;
        ovr_next     = ovr_reg;
        s1_info_next = s1_info_reg;

        if (rx_fire)
        begin
            if (!cfg.enable)
            begin
                fcount_next = '0;
            end
            else
            begin
                if (fcount_reg == '0)
                begin
                    hdr_next = rx_byte;
                end
                fcount_next = len;
                if (frame_end)
                begin
                    fcount_next = '0;
                    if (!frame_bad && (len > CNT_W'(1)))
                    begin
                        if (ready_reg)
                        begin
                            ovr_next = 1'b1;
                        end
                        else if (is_split && !seq_match)
                        begin
                            // new first half
                            a_slot_next  = rx_slot_reg;
                            rx_slot_next = a_slot_reg;
                            a_len_next   = plen;
                            pseq_next    = seq;
                            half_next    = 1'b1;
                        end
                        else if (is_split)
                        begin
                            // second half completes the packet
                            b_slot_next  = rx_slot_reg;
                            rx_slot_next = b_slot_reg;
                            pkt_len_next = LEN_W'(a_len_reg) + LEN_W'(plen);
                            half_next    = 1'b0;
                            rptr_next    = '0;
                            ready_next   = 1'b1;
                        end
                        else
                        begin
                            a_slot_next  = rx_slot_reg;
                            rx_slot_next = a_slot_reg;
                            a_len_next   = plen;
                            pkt_len_next = LEN_W'(plen);
                            half_next    = 1'b0;
                            rptr_next    = '0;
                            ready_next   = 1'b1;
                        end
                    end
                end
            end
        end
        else if (rd_fire)
        begin
            s1_info_next.overrun = ovr_reg;
            s1_info_next.valid   = rd_avail;
            s1_info_next.last    = rd_avail && (rptr_inc >= pkt_len_reg);
            ovr_next             = 1'b0;
            if (rd_avail)
            begin
                rptr_next = rptr_inc;
                if (rptr_inc >= pkt_len_reg)
                begin
                    ready_next = 1'b0;
                end
            end
            else
            begin
                ready_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fcount_reg   <= '0;
            hdr_reg      <= '0;
            rx_slot_reg  <= SLOT_RX_RST;
            a_slot_reg   <= SLOT_A_RST;
            b_slot_reg   <= SLOT_B_RST;
            a_len_reg    <= '0;
            half_reg     <= 1'b0;
            pseq_reg     <= '0;
            pkt_len_reg  <= '0;
            rptr_reg     <= '0;
            ready_reg    <= 1'b0;
            ovr_reg      <= 1'b0;
            s1_valid_reg <= 1'b0;
            s1_info_reg  <= '0;
        end
        else
        begin
            fcount_reg   <= fcount_next;
            hdr_reg      <= hdr_next;
            rx_slot_reg  <= rx_slot_next;
            a_slot_reg   <= a_slot_next;
            b_slot_reg   <= b_slot_next;
            a_len_reg    <= a_len_next;
            half_reg     <= half_next;
            pseq_reg     <= pseq_next;
            pkt_len_reg  <= pkt_len_next;
            rptr_reg     <= rptr_next;
            ready_reg    <= ready_next;
            ovr_reg      <= ovr_next;
            s1_valid_reg <= rd_fire;
            s1_info_reg  <= s1_info_next;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_info  = s1_info_reg;

endmodule

// ===== src/sfr_outq.sv =====
module sfr_outq (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    input  sfr_pkg::out_item_t              push_item,
    input  logic                            pop,
    output logic                            not_empty,
    output sfr_pkg::out_item_t              head,
    output logic [sfr_pkg::OUTQ_CNT_W-1:0]  count
);
    import sfr_pkg::*;

    out_item_t             q [0:OUTQ_DEPTH-1];
    logic [OUTQ_PTR_W-1:0] wr_ptr_reg;
    logic [OUTQ_PTR_W-1:0] rd_ptr_reg;
    logic [OUTQ_CNT_W-1:0] count_reg;
    logic                  do_pop;

    assign do_pop = pop && (count_reg != '0);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + OUTQ_PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + OUTQ_PTR_W'(1);
            end
            count_reg <= count_reg + OUTQ_CNT_W'(push) - OUTQ_CNT_W'(do_pop);
        end
    end

    assign not_empty = count_reg != '0;
    assign head      = q[rd_ptr_reg];
    assign count     = count_reg;

endmodule

// ===== src/split_frame_reassembler_top.sv =====
// channel | dir | beat fields
// s_*     | in  | tuser command, tdata rx_byte and frame_bad, tlast frame_end
// m_*     | out | tuser out_valid, tdata out_byte and overrun, tlast out_last
// apb     | in  | enable @0x0, split_flag_mask @0x4, seq_mask @0x8
//
// one beat per cycle in either direction when the output side keeps up
// a read beat's result is registered first at the frame memory read port,
// then in the output queue
// s_tready drops when the four-entry output queue plus the read in flight is full
// reset is asynchronous and leaves no packet and no held half; memory needs no clearing
module split_frame_reassembler_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [sfr_pkg::IN_DATA_W-1:0]       s_tdata,   // [7:0] rx_byte, [8] frame_bad
    input  logic                                s_tlast,
    input  logic                                s_tuser,   // [0] command
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [sfr_pkg::OUT_DATA_W-1:0]      m_tdata,   // [7:0] out_byte, [8] overrun
    output logic                                m_tlast,
    output logic                                m_tuser,   // [0] out_valid
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sfr_pkg::PADDR_W-1:0]         paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import sfr_pkg::*;

    cfg_t                  cfg;
    mem_wr_t               mem_wr;
    logic                  rd_en;
    logic [ADDR_W-1:0]     rd_addr;
    logic [7:0]            rd_data;
    logic                  s1_valid;
    rd_info_t              s1_info;
    out_item_t             push_item;
    out_item_t             head;
    logic [OUTQ_CNT_W-1:0] q_count;
    logic                  in_fire;
    logic [OUTQ_CNT_W:0]   pending;

    assign pending  = (OUTQ_CNT_W + 1)'(q_count) + (OUTQ_CNT_W + 1)'(s1_valid);
    assign s_tready = pending < (OUTQ_CNT_W + 1)'(OUTQ_DEPTH);
    assign in_fire  = s_tvalid && s_tready;

    sfr_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sfr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_fire   (in_fire),
        .command   (s_tuser),
        .rx_byte   (s_tdata[7:0]),
        .frame_end (s_tlast),
        .frame_bad (s_tdata[8]),
        .mem_wr    (mem_wr),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .s1_valid  (s1_valid),
        .s1_info   (s1_info)
    );

    sfr_ram u_ram (
        .clk     (clk),
        .wr      (mem_wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign push_item.overrun = s1_info.overrun;
    assign push_item.last    = s1_info.last;
    assign push_item.valid   = s1_info.valid;
    assign push_item.data    = s1_info.valid ? rd_data : 8'h00;

    sfr_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s1_valid),
        .push_item (push_item),
        .pop       (m_tready),
        .not_empty (m_tvalid),
        .head      (head),
        .count     (q_count)
    );

    assign m_tdata = {{(OUT_DATA_W - 9){1'b0}}, head.overrun, head.data};
    assign m_tlast = head.last;
    assign m_tuser = head.valid;

endmodule
